/* hw/rtl/pcw_pkg.sv */
// pcw_pkg: shared types and constants for the capability walker.
// Function codes, command/status structs, FSM states, field constants.
// No dependencies.
package pcw_pkg;

    localparam int DEF_CONFIG_DWORDS = 64;
    localparam int DEF_HOP_LIMIT     = 48;

    // function codes
    localparam logic [2:0] FN_WRITE = 3'd0;
    localparam logic [2:0] FN_READ  = 3'd1;
    localparam logic [2:0] FN_FIND  = 3'd2;
    localparam logic [2:0] FN_POWER = 3'd3;
    localparam logic [2:0] FN_WAKE  = 3'd4;

    // header types
    localparam logic [6:0] HDR_NORMAL  = 7'd0;
    localparam logic [6:0] HDR_BRIDGE  = 7'd1;
    localparam logic [6:0] HDR_CARDBUS = 7'd2;

    // fixed dword locations
    localparam logic [6:0] STAT_DWORD    = 7'd1;   // status word at byte 0x06
    localparam logic [6:0] HEAD_DWORD    = 7'd13;  // list head at byte 0x34
    localparam logic [6:0] CB_HEAD_DWORD = 7'd5;   // cardbus list head at byte 0x14

    localparam logic [7:0] PM_CAP_ID      = 8'h01;
    localparam logic [7:0] MIN_CAP_OFFSET = 8'h40;
    localparam logic [7:0] END_ID         = 8'hff;
    localparam logic [7:0] OFFSET_MASK    = 8'hfc;

    localparam logic [1:0] PWR_D0 = 2'd0;
    localparam logic [1:0] PWR_D1 = 2'd1;
    localparam logic [1:0] PWR_D2 = 2'd2;
    localparam logic [1:0] PWR_D3 = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_UNSUP   = 2'd2;

    localparam logic [1:0] DLY_NONE  = 2'd0;
    localparam logic [1:0] DLY_SHORT = 2'd1;
    localparam logic [1:0] DLY_LONG  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_CAP_STAT,
        ST_CAP_HEAD,
        ST_CAP_TEST,
        ST_CAP_HOP,
        ST_CAP_END,
        ST_CTRL_RD
    } pcw_state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_STAT,
        RD_HEAD,
        RD_POS,
        RD_CTRL
    } pcw_rdsel_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_READ,
        RES_FIND,
        RES_INVALID,
        RES_UNSUP,
        RES_WAKE_NOPM,
        RES_WAKE_REJ,
        RES_POWER
    } pcw_res_t;

    typedef struct packed {
        logic       latch_in;
        logic       wr_dword;
        logic       ctrl_write;
        logic       load_head;
        logic       hop_step;
        logic       load_next;
        logic       set_found;
        logic       set_absent;
        logic       finish;
        pcw_rdsel_t rd_sel;
        pcw_res_t   res;
    } pcw_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       pwr_invalid;
        logic       pwr_same;
        logic       list_ok;
        logic       hdr_list;
        logic       walk_go;
        logic       id_end;
        logic       id_match;
        logic       pm_absent;
        logic       pm_unsup;
        logic       wake_rej;
    } pcw_stat_t;

endpackage

/* hw/rtl/pcw_ram.sv */
// pcw_ram: generic single-write, single-read RAM with registered read.
// Depends on nothing.
module pcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pcw_ctrl.sv */
// pcw_ctrl: operation sequencer for the capability walker.
// Drives pcw_cmd_t to the datapath, reads pcw_stat_t. Uses pcw_pkg.
module pcw_ctrl
    import pcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pcw_stat_t stat,
    output pcw_cmd_t  cmd
);

    pcw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.res    = RES_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.func) inside
                    FN_WRITE:
                    begin
                        cmd.wr_dword = 1'b1;
                        cmd.finish   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    FN_READ:
                    begin
                        cmd.rd_sel = RD_IDX;
                        state_next = ST_RD_WAIT;
                    end
                    FN_FIND, FN_WAKE:
                    begin
                        cmd.rd_sel = RD_STAT;
                        state_next = ST_CAP_STAT;
                    end
                    FN_POWER:
                    begin
                        if (stat.pwr_invalid)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = RES_INVALID;
                            state_next = ST_IDLE;
                        end
                        else if (stat.pwr_same)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_STAT;
                            state_next = ST_CAP_STAT;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                cmd.finish = 1'b1;
                cmd.res    = RES_READ;
                state_next = ST_IDLE;
            end
            ST_CAP_STAT:
            begin
                if (stat.list_ok && stat.hdr_list)
                begin
                    cmd.rd_sel = RD_HEAD;
                    state_next = ST_CAP_HEAD;
                end
                else
                begin
                    cmd.set_absent = 1'b1;
                    state_next     = ST_CAP_END;
                end
            end
            ST_CAP_HEAD:
            begin
                cmd.load_head = 1'b1;
                state_next    = ST_CAP_TEST;
            end
            ST_CAP_TEST:
            begin
                if (stat.walk_go)
                begin
                    cmd.hop_step = 1'b1;
                    cmd.rd_sel   = RD_POS;
                    state_next   = ST_CAP_HOP;
                end
                else
                begin
                    cmd.set_absent = 1'b1;
                    state_next     = ST_CAP_END;
                end
            end
            ST_CAP_HOP:
            begin
                if (stat.id_end)
                begin
                    cmd.set_absent = 1'b1;
                    state_next     = ST_CAP_END;
                end
                else if (stat.id_match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_CAP_END;
                end
                else
                begin
                    cmd.load_next = 1'b1;
                    state_next    = ST_CAP_TEST;
                end
            end
            ST_CAP_END:
            begin
                if (stat.func == FN_FIND)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = RES_FIND;
                    state_next = ST_IDLE;
                end
                else if (stat.pm_absent)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = (stat.func == FN_POWER) ? RES_UNSUP : RES_WAKE_NOPM;
                    state_next = ST_IDLE;
                end
                else if (stat.func == FN_POWER && stat.pm_unsup)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = RES_UNSUP;
                    state_next = ST_IDLE;
                end
                else if (stat.func == FN_WAKE && stat.wake_rej)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = RES_WAKE_REJ;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_CTRL;
                    state_next = ST_CTRL_RD;
                end
            end
            ST_CTRL_RD:
            begin
                // read-modify-write of the PM control word, then respond
                cmd.ctrl_write = 1'b1;
                cmd.finish     = 1'b1;
                cmd.res        = (stat.func == FN_POWER) ? RES_POWER : RES_NONE;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");

    a_start_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_DISPATCH)
        else $error("accepted item not dispatched");

    a_hop_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CAP_HOP |-> $past(state_reg) == ST_CAP_TEST)
        else $error("hop state entered out of order");
`endif

endmodule

/* hw/rtl/pcw_dpath.sv */
// pcw_dpath: config-space storage, walk registers, power state and result regs.
// Uses pcw_pkg and pcw_ram; controlled by pcw_ctrl through pcw_cmd_t.
module pcw_dpath
    import pcw_pkg::*;
#(
    parameter int CONFIG_DWORDS = DEF_CONFIG_DWORDS,
    parameter int HOP_LIMIT     = DEF_HOP_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic [2:0]  func,
    input  logic [5:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [7:0]  cap_id,
    input  logic [2:0]  power_state,
    input  logic        wake_enable,
    input  pcw_cmd_t    cmd,
    output pcw_stat_t   stat,
    output logic        done,
    output logic [31:0] read_data,
    output logic [7:0]  cap_offset,
    output logic [1:0]  status,
    output logic [1:0]  delay_class
);

    localparam int AW = $clog2(CONFIG_DWORDS);
    localparam int HW = $clog2(HOP_LIMIT + 1);
    localparam logic [6:0]    DEPTH7   = 7'(CONFIG_DWORDS);
    localparam logic [HW-1:0] HOP_INIT = HW'(HOP_LIMIT);

    logic [6:0]    hdr_reg;
    logic [2:0]    func_reg;
    logic [5:0]    idx_reg;
    logic [31:0]   wdata_reg;
    logic [7:0]    cap_reg;
    logic [2:0]    pstate_reg;
    logic          wen_reg;
    logic [1:0]    cur_reg;
    logic [7:0]    pos_reg;
    logic [HW-1:0] hops_reg;
    logic [7:0]    pm_reg;
    logic [15:0]   pmc_reg;
    logic [CONFIG_DWORDS-1:0] valid_reg;
    logic          rd_hit_reg;

    logic          done_reg;
    logic [31:0]   read_data_reg;
    logic [7:0]    cap_offset_reg;
    logic [1:0]    status_reg;
    logic [1:0]    delay_reg;

    logic [1:0]    tgt;
    logic [6:0]    ctrl_dw;
    logic [6:0]    rd_dw;
    logic          rd_in;
    logic [6:0]    wr_dw;
    logic [31:0]   wr_data;
    logic          wr_ok;
    logic [15:0]   ctrl_low;
    logic [31:0]   ram_q;
    logic [31:0]   rdata;
    logic [7:0]    match_id;
    logic [7:0]    sup8;
    logic [1:0]    dly;

    pcw_ram #(
        .WIDTH (32),
        .DEPTH (CONFIG_DWORDS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (wr_dw[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_dw[AW-1:0]),
        .rdata (ram_q)
    );

    assign tgt      = (pstate_reg > 3'd3) ? PWR_D3 : pstate_reg[1:0];
    assign ctrl_dw  = {1'b0, pm_reg[7:2]} + 7'd1;
    assign rdata    = rd_hit_reg ? ram_q : 32'd0;
    assign match_id = (func_reg == FN_FIND) ? cap_reg : PM_CAP_ID;
    assign sup8     = {3'b000, pmc_reg[15:11]};

    // read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  rd_dw = {1'b0, idx_reg};
            RD_STAT: rd_dw = STAT_DWORD;
            RD_HEAD: rd_dw = (hdr_reg == HDR_CARDBUS) ? CB_HEAD_DWORD : HEAD_DWORD;
            RD_POS:  rd_dw = {1'b0, pos_reg[7:2]};
            RD_CTRL: rd_dw = ctrl_dw;
            default: rd_dw = 7'd0;
        endcase
    end

    assign rd_in = (rd_dw < DEPTH7);

    // PM control word rewrite
    always_comb
    begin
        if (func_reg == FN_POWER)
        begin
            ctrl_low = (cur_reg == PWR_D3) ? 16'd0 : {rdata[15:2], tgt};
        end
        else
        begin
            ctrl_low = {1'b1, rdata[14:9], wen_reg, rdata[7:0]};
        end
    end

    assign wr_dw   = cmd.ctrl_write ? ctrl_dw : {1'b0, idx_reg};
    assign wr_data = cmd.ctrl_write ? {rdata[31:16], ctrl_low} : wdata_reg;
    assign wr_ok   = (cmd.wr_dword || cmd.ctrl_write) && (wr_dw < DEPTH7);

    always_comb
    begin
        if (tgt == PWR_D3 || cur_reg == PWR_D3)
        begin
            dly = DLY_LONG;
        end
        else if (tgt == PWR_D2 || cur_reg == PWR_D2)
        begin
            dly = DLY_SHORT;
        end
        else
        begin
            dly = DLY_NONE;
        end
    end

    always_comb
    begin
        stat.func        = func_reg;
        stat.pwr_invalid = (tgt != PWR_D0) && (cur_reg > tgt);
        stat.pwr_same    = (cur_reg == tgt);
        stat.list_ok     = rdata[20];
        stat.hdr_list    = (hdr_reg == HDR_NORMAL) || (hdr_reg == HDR_BRIDGE)
                           || (hdr_reg == HDR_CARDBUS);
        stat.walk_go     = (hops_reg != '0) && (pos_reg >= MIN_CAP_OFFSET);
        stat.id_end      = (rdata[7:0] == END_ID);
        stat.id_match    = (rdata[7:0] == match_id);
        stat.pm_absent   = (pm_reg == 8'd0);
        stat.pm_unsup    = (tgt == PWR_D1 && !pmc_reg[9]) || (tgt == PWR_D2 && !pmc_reg[10]);
        stat.wake_rej    = (pmc_reg[15:11] == 5'd0) || !sup8[pstate_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg    <= HDR_NORMAL;
            cur_reg    <= PWR_D0;
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hdr_reg <= cfg_wdata;
            end
            if (cmd.ctrl_write && func_reg == FN_POWER)
            begin
                cur_reg <= tgt;
            end
            if (wr_ok)
            begin
                valid_reg[wr_dw[AW-1:0]] <= 1'b1;
            end
            rd_hit_reg <= rd_in && valid_reg[rd_dw[AW-1:0]];
            done_reg   <= cmd.finish;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg   <= func;
            idx_reg    <= reg_index;
            wdata_reg  <= write_data;
            cap_reg    <= cap_id;
            pstate_reg <= power_state;
            wen_reg    <= wake_enable;
        end
        if (cmd.load_head)
        begin
            pos_reg  <= rdata[7:0];
            hops_reg <= HOP_INIT;
        end
        else if (cmd.hop_step)
        begin
            pos_reg  <= pos_reg & OFFSET_MASK;
            hops_reg <= hops_reg - HW'(1);
        end
        else if (cmd.load_next)
        begin
            pos_reg <= rdata[15:8];
        end
        if (cmd.set_found)
        begin
            pm_reg  <= pos_reg;
            pmc_reg <= rdata[31:16];
        end
        else if (cmd.set_absent)
        begin
            pm_reg <= 8'd0;
        end
        if (cmd.finish)
        begin
            read_data_reg  <= (cmd.res == RES_READ) ? rdata : 32'd0;
            cap_offset_reg <= (cmd.res == RES_FIND) ? pm_reg : 8'd0;
            delay_reg      <= (cmd.res == RES_POWER) ? dly : DLY_NONE;
            case (cmd.res)
                RES_INVALID:   status_reg <= STS_INVALID;
                RES_UNSUP:     status_reg <= STS_UNSUP;
                RES_WAKE_NOPM: status_reg <= wen_reg ? STS_UNSUP : STS_OK;
                RES_WAKE_REJ:  status_reg <= wen_reg ? STS_INVALID : STS_OK;
                default:       status_reg <= STS_OK;
            endcase
        end
    end

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign cap_offset  = cap_offset_reg;
    assign status      = status_reg;
    assign delay_class = delay_reg;

`ifndef NO_ASSERTIONS
    a_hops_left: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hop_step |-> hops_reg != '0)
        else $error("hop taken with no hops left");

    a_ctrl_has_pm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ctrl_write |-> pm_reg != 8'd0)
        else $error("control word write without PM capability");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held over two cycles");
`endif

endmodule

/* hw/rtl/pci_capability_walk_and_power_state_top.sv */
// Write, unknown codes and power requests refused or already met finish at dispatch;
// read does one RAM read; search, power and wake with no list stop after the status
// word; otherwise the walk reads the head, then hops until a hit, an end marker or
// it runs out (plus the control word access for power and wake); hops up to HOP_LIMIT.
// One item at a time, busy while working; each hop is one RAM read, one decision.
// Reset: config space reads as zero (per-dword valid bits), power state D0,
// header type 0. The receiver cannot stall; done is a one-cycle strobe.
module pci_capability_walk_and_power_state_top
    import pcw_pkg::*;
#(
    parameter int CONFIG_DWORDS = DEF_CONFIG_DWORDS,
    parameter int HOP_LIMIT     = DEF_HOP_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: header type register
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // item in
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [5:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [7:0]  cap_id,
    input  logic [2:0]  power_state,
    input  logic        wake_enable,
    // result out
    output logic        done,
    output logic [31:0] read_data,
    output logic [7:0]  cap_offset,
    output logic [1:0]  status,
    output logic [1:0]  delay_class
);

    pcw_cmd_t  cmd;
    pcw_stat_t stat;

    // sequencer: dispatch, list walk, PM control word update
    pcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // storage, walk pointer/hop count, power state, result registers
    pcw_dpath #(
        .CONFIG_DWORDS (CONFIG_DWORDS),
        .HOP_LIMIT     (HOP_LIMIT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .cap_id      (cap_id),
        .power_state (power_state),
        .wake_enable (wake_enable),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .read_data   (read_data),
        .cap_offset  (cap_offset),
        .status      (status),
        .delay_class (delay_class)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for pci_capability_walk_and_power_state_top.
// Depends on pcw_pkg (function codes, status and delay codes, list constants)
// and the top-level RTL; all stimulus and expected results are built in place.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcw_pkg::*;

    // ------------------------------------------------------------------
    // Sizes and limits
    // ------------------------------------------------------------------
    localparam int CFG_DWORDS  = DEF_CONFIG_DWORDS;
    localparam int WALK_HOPS   = DEF_HOP_LIMIT;
    localparam int TARGET_ITEMS = 1750;
    // The watchdog limit sits well above the slowest item plus the longest sender gap
    // before calling the run hung.
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 150;

    // Byte offsets inside config space used by the list walk
    localparam int unsigned STAT_WORD_OFF = 8'h06;
    localparam int unsigned HEAD_OFF      = 8'h34;
    localparam int unsigned CB_HEAD_OFF   = 8'h14;
    localparam int CAP_LIST_BIT   = 4;    // in the status word
    localparam int PMC_D1_BIT     = 9;
    localparam int PMC_D2_BIT     = 10;
    localparam int PME_EN_BIT     = 8;
    localparam int PME_STATUS_BIT = 15;
    localparam int STAT_DWORD_CAP_BIT = 20;   // capability-list bit seen as a dword bit

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;   // header-type write instead of an item
        logic [6:0]  hdr;
        int unsigned gap;      // idle cycles before this entry is driven
        logic [2:0]  fn;
        logic [5:0]  idx;
        logic [31:0] wdata;
        logic [7:0]  cid;
        logic [2:0]  ps;
        logic        wen;
    } cmd_entry_t;

    typedef struct packed {
        logic [31:0] rd;
        logic [7:0]  off;
        logic [1:0]  sts;
        logic [1:0]  dly;
    } walk_result_t;

    // ------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = '0;
    logic [5:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic [7:0]  cap_id = '0;
    logic [2:0]  power_state = '0;
    logic        wake_enable = 1'b0;
    logic        done;
    logic [31:0] read_data;
    logic [7:0]  cap_offset;
    logic [1:0]  status;
    logic [1:0]  delay_class;

    pci_capability_walk_and_power_state_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .cap_id      (cap_id),
        .power_state (power_state),
        .wake_enable (wake_enable),
        .done        (done),
        .read_data   (read_data),
        .cap_offset  (cap_offset),
        .status      (status),
        .delay_class (delay_class)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    cmd_entry_t   cmd_backlog[$];     // filled up front, drained by the driver
    walk_result_t due_results[$];     // one per accepted item, oldest first
    logic [7:0]   list_ids[$];        // ids of the list built in this phase

    // shadow of the block's state
    logic [31:0] shadow_space [CFG_DWORDS];
    logic [1:0]  shadow_pwr;
    logic [6:0]  shadow_hdr;

    cmd_entry_t  cur_cmd;
    bit          have_cur = 1'b0;
    int unsigned gap_left = 0;
    bit          taken = 1'b0;        // item on the ports was accepted at last rising edge
    logic        drive_start;
    logic        drive_we;
    int unsigned issued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned stall_cycles = 0;
    int unsigned err_count = 0;
    int unsigned item_total = 0;
    bit          no_gaps = 1'b0;      // phase runs back to back
    bit          slot_used [64];

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow config-space access; anything past the last dword reads 0
    // and swallows writes.
    // ------------------------------------------------------------------
    function automatic logic [7:0] space_byte(input int unsigned off);
        if ((off >> 2) >= CFG_DWORDS)
            return 8'h00;
        return shadow_space[off >> 2][(off % 4) * 8 +: 8];
    endfunction

    function automatic logic [15:0] space_word(input int unsigned off);
        if ((off >> 2) >= CFG_DWORDS)
            return 16'h0000;
        return shadow_space[off >> 2][(off & 2) * 8 +: 16];
    endfunction

    function automatic void space_put_word(input int unsigned off, input logic [15:0] v);
        if ((off >> 2) >= CFG_DWORDS)
            return;
        shadow_space[off >> 2][(off & 2) * 8 +: 16] = v;
    endfunction

    // Follow the capability list; 0 when the id is absent.
    function automatic int unsigned cap_location(input logic [7:0] wanted);
        int unsigned pos;
        int          hops;
        logic [7:0]  id;
        logic [15:0] stat_word;
        hops = WALK_HOPS;
        stat_word = space_word(STAT_WORD_OFF);
        if (!stat_word[CAP_LIST_BIT])
            return 0;
        if (shadow_hdr == HDR_NORMAL || shadow_hdr == HDR_BRIDGE)
            pos = 32'(space_byte(HEAD_OFF));
        else if (shadow_hdr == HDR_CARDBUS)
            pos = 32'(space_byte(CB_HEAD_OFF));
        else
            return 0;
        while (hops > 0 && pos >= MIN_CAP_OFFSET) begin
            hops--;
            pos = pos & 32'(OFFSET_MASK);
            id = space_byte(pos);
            if (id == END_ID)
                break;
            if (id == wanted)
                return pos;
            pos = 32'(space_byte(pos + 1));
        end
        return 0;
    endfunction

    // Expected result of one item; updates the shadow state as the block would.
    function automatic walk_result_t walk_and_power_outcome(
        input logic [2:0]  fn,
        input logic [5:0]  idx,
        input logic [31:0] wd,
        input logic [7:0]  cid,
        input logic [2:0]  ps,
        input logic        en
    );
        walk_result_t r;
        int unsigned  pm;
        logic [15:0]  pmc;
        logic [15:0]  ctrl;
        logic [4:0]   sup;
        logic [1:0]   tgt;
        r = '0;
        case (fn)
            FN_WRITE: shadow_space[idx] = wd;
            FN_READ:  r.rd = shadow_space[idx];
            FN_FIND:  r.off = 8'(cap_location(cid));
            FN_POWER: begin
                tgt = (ps > 3) ? PWR_D3 : ps[1:0];
                if (tgt != PWR_D0 && shadow_pwr > tgt) begin
                    r.sts = STS_INVALID;
                end else if (shadow_pwr != tgt) begin
                    pm = cap_location(PM_CAP_ID);
                    pmc = space_word(pm + 2);
                    if (pm == 0) begin
                        r.sts = STS_UNSUP;
                    end else if ((tgt == PWR_D1 && !pmc[PMC_D1_BIT]) ||
                                 (tgt == PWR_D2 && !pmc[PMC_D2_BIT])) begin
                        r.sts = STS_UNSUP;
                    end else begin
                        // leaving D3 clears the control word
                        if (shadow_pwr == PWR_D3) begin
                            ctrl = '0;
                        end else begin
                            ctrl = space_word(pm + 4);
                            ctrl[1:0] = tgt;
                        end
                        space_put_word(pm + 4, ctrl);
                        if (tgt == PWR_D3 || shadow_pwr == PWR_D3)
                            r.dly = DLY_LONG;
                        else if (tgt == PWR_D2 || shadow_pwr == PWR_D2)
                            r.dly = DLY_SHORT;
                        else
                            r.dly = DLY_NONE;
                        shadow_pwr = tgt;
                    end
                end
            end
            FN_WAKE: begin
                pm = cap_location(PM_CAP_ID);
                if (pm == 0) begin
                    r.sts = en ? STS_UNSUP : STS_OK;
                end else begin
                    pmc = space_word(pm + 2);
                    sup = pmc[15:11];
                    // source states 5..7 have no support bit
                    if (sup == 0 || ps > 4 || !sup[ps]) begin
                        r.sts = en ? STS_INVALID : STS_OK;
                    end else begin
                        ctrl = space_word(pm + 4);
                        ctrl[PME_STATUS_BIT] = 1'b1;
                        ctrl[PME_EN_BIT] = en;
                        space_put_word(pm + 4, ctrl);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one entry at a time, inputs change on the falling edge.
    // An item is held until a rising edge sees start high with busy low.
    // Header writes wait until every expected result is back.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            drive_start = 1'b0;
            drive_we = 1'b0;
            if (start && !taken) begin
                drive_start = 1'b1;
            end else begin
                if (!have_cur && cmd_backlog.size() != 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur_cmd.gap;
                end
                if (have_cur) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (cur_cmd.is_cfg) begin
                        if (due_results.size() == 0 && !busy) begin
                            drive_we = 1'b1;
                            cfg_wdata <= cur_cmd.hdr;
                            have_cur = 1'b0;
                        end
                    end else begin
                        drive_start = 1'b1;
                        func        <= cur_cmd.fn;
                        reg_index   <= cur_cmd.idx;
                        write_data  <= cur_cmd.wdata;
                        cap_id      <= cur_cmd.cid;
                        power_state <= cur_cmd.ps;
                        wake_enable <= cur_cmd.wen;
                        issued_cnt++;
                        have_cur = 1'b0;
                    end
                end
            end
            start  <= drive_start;
            cfg_we <= drive_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, predict accepted items, track header
    // writes and compare each done strobe with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            taken <= start && !busy;
            if (cfg_we)
                shadow_hdr = cfg_wdata;
            if (start && !busy) begin
                due_results.push_back(walk_and_power_outcome(func, reg_index, write_data,
                                                             cap_id, power_state,
                                                             wake_enable));
                accepted_cnt++;
            end
            if (done) begin
                if (due_results.size() == 0) begin
                    $error("result with no item outstanding");
                    err_count++;
                end else begin
                    walk_result_t want;
                    want = due_results.pop_front();
                    if (read_data !== want.rd) begin
                        $error("read_data: expected %h, got %h", want.rd, read_data);
                        err_count++;
                    end
                    if (cap_offset !== want.off) begin
                        $error("cap_offset: expected %h, got %h", want.off, cap_offset);
                        err_count++;
                    end
                    if (status !== want.sts) begin
                        $error("status: expected %0d, got %0d", want.sts, status);
                        err_count++;
                    end
                    if (delay_class !== want.dly) begin
                        $error("delay_class: expected %0d, got %0d", want.dly, delay_class);
                        err_count++;
                    end
                end
            end
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Hang detection: nothing accepted, answered or written for too long
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(input logic [2:0] fn, input logic [5:0] idx,
                             input logic [31:0] wd, input logic [7:0] cid,
                             input logic [2:0] ps, input logic en);
        cmd_entry_t c;
        c.is_cfg = 1'b0;
        c.hdr    = '0;
        c.gap    = pick_gap();
        c.fn     = fn;
        c.idx    = idx;
        c.wdata  = wd;
        c.cid    = cid;
        c.ps     = ps;
        c.wen    = en;
        cmd_backlog.push_back(c);
        item_total++;
    endtask

    task automatic push_hdr(input logic [6:0] v);
        cmd_entry_t c;
        c = '{default: '0};
        c.is_cfg = 1'b1;
        c.hdr    = v;
        c.gap    = pick_gap();
        cmd_backlog.push_back(c);
    endtask

    // Lay down a capability list through dword writes: status bit, head
    // pointer for the header in use, then the chain with random tails
    // (plain end, pointer below 0x40, loop back, or anything).
    task automatic build_list(input logic [6:0] hdr);
        int unsigned slots[$];
        int unsigned n;
        int unsigned d;
        int unsigned pm_slot;
        int unsigned i;
        bit          with_pm;
        logic [5:0]  head_dw;
        logic [7:0]  id;
        logic [7:0]  nxt;
        logic [31:0] w;
        list_ids.delete();
        foreach (slot_used[k])
            slot_used[k] = 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        while (slots.size() < n) begin
            d = $urandom_range(16, 63);
            if (!slot_used[d]) begin
                slot_used[d] = 1'b1;
                slots.push_back(d);
            end
        end

        w = $urandom;
        w[STAT_DWORD_CAP_BIT] = ($urandom_range(0, 7) != 0);
        push_item(FN_WRITE, 6'(STAT_DWORD), w, 8'($urandom), 3'($urandom), 1'($urandom));

        // head pointer; once in a while placed for the other header layout
        head_dw = (hdr == HDR_CARDBUS) ? 6'(CB_HEAD_DWORD) : 6'(HEAD_DWORD);
        if ($urandom_range(0, 7) == 0)
            head_dw = (head_dw == 6'(HEAD_DWORD)) ? 6'(CB_HEAD_DWORD) : 6'(HEAD_DWORD);
        w = $urandom;
        w[7:0] = 8'(slots[0] * 4 + $urandom_range(0, 3));
        push_item(FN_WRITE, head_dw, w, 8'($urandom), 3'($urandom), 1'($urandom));

        with_pm = ($urandom_range(0, 3) != 0);
        pm_slot = $urandom_range(0, n - 1);
        for (i = 0; i < n; i++) begin
            if (with_pm && i == pm_slot)
                id = PM_CAP_ID;
            else if ($urandom_range(0, 15) == 0)
                id = END_ID;
            else
                id = 8'($urandom_range(0, 254));
            if (i + 1 < n) begin
                nxt = 8'(slots[i + 1] * 4 + $urandom_range(0, 3));
            end else begin
                case ($urandom_range(0, 3))
                    0:       nxt = 8'h00;
                    1:       nxt = 8'($urandom_range(0, 63));
                    2:       nxt = 8'(slots[$urandom_range(0, i)] * 4);
                    default: nxt = 8'($urandom);
                endcase
            end
            w = {16'($urandom), nxt, id};
            push_item(FN_WRITE, 6'(slots[i]), w, 8'($urandom), 3'($urandom), 1'($urandom));
            list_ids.push_back(id);
            // seed the PM control word now and then
            if (with_pm && i == pm_slot && slots[i] < 63 && $urandom_range(0, 1) == 1)
                push_item(FN_WRITE, 6'(slots[i] + 1), $urandom, 8'($urandom),
                          3'($urandom), 1'($urandom));
        end
    endtask

    // Mixed traffic against the list in place; unused fields stay random
    task automatic run_ops(input int unsigned count);
        int unsigned k;
        int unsigned r;
        logic [7:0]  cid;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            cid = 8'($urandom);
            if (r < 30) begin
                if (list_ids.size() != 0 && $urandom_range(0, 9) < 7)
                    cid = list_ids[$urandom_range(0, list_ids.size() - 1)];
                push_item(FN_FIND, 6'($urandom), $urandom, cid, 3'($urandom), 1'($urandom));
            end else if (r < 50) begin
                push_item(FN_POWER, 6'($urandom), $urandom, cid, 3'($urandom), 1'($urandom));
            end else if (r < 65) begin
                push_item(FN_WAKE, 6'($urandom), $urandom, cid, 3'($urandom), 1'($urandom));
            end else if (r < 78) begin
                push_item(FN_READ, 6'($urandom), $urandom, cid, 3'($urandom), 1'($urandom));
            end else if (r < 90) begin
                push_item(FN_WRITE, 6'($urandom), $urandom, cid, 3'($urandom), 1'($urandom));
            end else if (r < 97) begin
                // read back list dwords
                push_item(FN_READ, 6'($urandom_range(16, 63)), $urandom, cid,
                          3'($urandom), 1'($urandom));
            end else begin
                // unused function codes 5..7
                push_item(3'($urandom_range(5, 7)), 6'($urandom), $urandom, cid,
                          3'($urandom), 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [6:0]  hdr;
        int unsigned r;

        foreach (shadow_space[k])
            shadow_space[k] = '0;
        shadow_pwr = PWR_D0;
        shadow_hdr = HDR_NORMAL;

        // Directed: empty space first, header type as after reset
        push_item(FN_READ,  6'd0, '0, 8'h00, 3'd0, 1'b0);
        push_item(FN_FIND,  6'd0, '0, PM_CAP_ID, 3'd0, 1'b0);   // list bit clear
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd1, 1'b0);       // no PM capability
        push_item(FN_WAKE,  6'd0, '0, 8'h00, 3'd0, 1'b1);
        push_item(FN_WAKE,  6'd0, '0, 8'h00, 3'd0, 1'b0);
        push_item(FN_WRITE, 6'd0, 32'h0000_0000, 8'h00, 3'd0, 1'b0);
        // list: head 0x43 (low bits masked) -> PM at 0x40 -> 0x50 -> 0xFC
        push_item(FN_WRITE, 6'(STAT_DWORD), 32'h0010_0000, 8'h00, 3'd0, 1'b0);
        push_item(FN_WRITE, 6'(HEAD_DWORD), 32'h0000_0043, 8'h00, 3'd0, 1'b0);
        push_item(FN_WRITE, 6'd16, 32'hFE03_5001, 8'h00, 3'd0, 1'b0);
        push_item(FN_WRITE, 6'd20, 32'h0000_FC10, 8'h00, 3'd0, 1'b0);
        push_item(FN_WRITE, 6'd63, 32'h0000_0005, 8'h00, 3'd0, 1'b0);
        push_item(FN_FIND,  6'd0, '0, 8'h05, 3'd0, 1'b0);       // last dword
        push_item(FN_FIND,  6'd0, '0, 8'h10, 3'd0, 1'b0);
        push_item(FN_FIND,  6'd0, '0, END_ID, 3'd0, 1'b0);      // end marker never matches
        push_item(FN_FIND,  6'd0, '0, 8'h77, 3'd0, 1'b0);       // absent
        // power ladder: D1, D2, back to D1 refused, D3 via clamp, D0, same
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd1, 1'b0);
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd2, 1'b0);
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd1, 1'b0);
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd7, 1'b0);
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd0, 1'b0);
        push_item(FN_POWER, 6'd0, '0, 8'h00, 3'd0, 1'b0);
        // wake: supported source, source without a support bit, disable
        push_item(FN_WAKE,  6'd0, '0, 8'h00, 3'd0, 1'b1);
        push_item(FN_WAKE,  6'd0, '0, 8'h00, 3'd5, 1'b1);
        push_item(FN_WAKE,  6'd0, '0, 8'h00, 3'd4, 1'b0);
        push_item(FN_READ,  6'd17, '0, 8'h00, 3'd0, 1'b0);
        // last capability points at itself: walk runs out of hops
        push_item(FN_WRITE, 6'd63, 32'hFFFF_FC05, 8'hFF, 3'd7, 1'b1);
        push_item(FN_READ,  6'd63, 32'hFFFF_FFFF, 8'h00, 3'd0, 1'b0);
        push_item(FN_FIND,  6'd0, '0, 8'h33, 3'd0, 1'b0);
        push_item(3'd7,     6'd63, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b1);
        // cardbus head is empty; header 127 has no list
        push_hdr(HDR_CARDBUS);
        push_item(FN_FIND,  6'd0, '0, PM_CAP_ID, 3'd0, 1'b0);
        push_hdr(7'h7F);
        push_item(FN_FIND,  6'd0, '0, PM_CAP_ID, 3'd0, 1'b0);

        // Random phases: new header, fresh list, then mixed traffic
        while (item_total < TARGET_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                hdr = HDR_NORMAL;
            else if (r < 65)
                hdr = HDR_BRIDGE;
            else if (r < 90)
                hdr = HDR_CARDBUS;
            else if (r < 95)
                hdr = 7'h7F;
            else
                hdr = 7'($urandom_range(3, 127));
            push_hdr(hdr);
            build_list(hdr);
            run_ops($urandom_range(30, 50));
        end

        // Everything accepted and answered, then let the block settle
        wait (cmd_backlog.size() == 0 && !have_cur && issued_cnt == accepted_cnt &&
              due_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
